[sv/fnvws_pkg.sv]
// Shared constants, types and the prime multiply for the FNV-64 word stream hash.
`timescale 1ns / 1ps

package fnvws_pkg;

  localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;
  localparam logic [63:0] PAD_BYTE  = 64'h01;

  // Controller to datapath commands
  typedef struct packed {
    logic take;     // item accepted this cycle
    logic pad;      // absorb padded partial word
    logic len;      // absorb message length
    logic emit;     // load result and clear message state
  } dp_cmd_t;

  // Datapath to controller status, for the values after the current item
  typedef struct packed {
    logic len_next_zero;
    logic pos_next_zero;
  } dp_stat_t;

  // Multiply by the FNV prime 2^40 + 0x1B3, modulo 2^64, as a shift-add
  function automatic logic [63:0] fnv_mul(input logic [63:0] x);
    fnv_mul = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

[sv/fnv64_word_stream_hash_top.sv]
// Top level of the FNV-64 word stream hash.
`timescale 1ns / 1ps

// Byte-serial FNV-1a style 64-bit hash over little-endian 64-bit words. Every item
// that is not marked last leaves the input ready for the next item, including the
// byte that completes a word: the multiply by the prime (2^40 + 0x1B3) is a
// combinational shift-add on the running hash. An item marked last stalls the input
// until the block has taken the item, absorbed the padded partial word if any,
// absorbed the byte count if the message is not empty, and loaded the result register,
// which waits while a previous result is still stalled. Non-last items are accepted
// while a result waits at the output. After each last item the hash returns to
// the offset basis and the word, position and length are cleared.
module fnv64_word_stream_hash_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o
);

  fnvws_pkg::dp_cmd_t  cmd;
  fnvws_pkg::dp_stat_t stat;

  fnvws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_i      (last_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fnvws_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .stat_o         (stat),
    .hash_value_o   (hash_value_o)
  );

  // A non-last item leaves the block ready for the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !last_i) |=> !in_stall_o)
    else $error("block busy after non-last item");

  // A last item always starts the finishing sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_i) |=> in_stall_o)
    else $error("last item did not start finishing");

  // A new result only appears at the end of a finishing sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result raised outside finishing sequence");

endmodule

[sv/fnvws_dp.sv]
// Datapath: word assembly, length counter, running hash and result register.
`timescale 1ns / 1ps

module fnvws_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fnvws_pkg::dp_cmd_t cmd_i,
  input  logic [7:0]         data_byte_i,
  input  logic               byte_present_i,
  output fnvws_pkg::dp_stat_t stat_o,
  output logic [63:0]        hash_value_o
);

  logic [63:0] hash_q, hash_d;
  logic [63:0] word_q, word_d;
  logic [2:0]  pos_q, pos_d;
  logic [63:0] len_q, len_d;
  logic [63:0] out_q;

  logic [63:0] word_ins;
  logic [63:0] len_inc;
  logic        full;
  logic [63:0] operand;
  logic [63:0] product;

  assign word_ins = word_q | ({56'd0, data_byte_i} << {pos_q, 3'b000});
  assign len_inc  = len_q + 64'd1;
  assign full     = (pos_q == 3'd7);

  always_comb begin
    priority if (cmd_i.pad) begin
      operand = word_q | (fnvws_pkg::PAD_BYTE << {pos_q, 3'b000});
    end else if (cmd_i.len) begin
      operand = len_q;
    end else begin
      operand = word_ins;
    end
  end

  assign product = fnvws_pkg::fnv_mul(hash_q ^ operand);

  assign stat_o.len_next_zero = byte_present_i ? (len_inc == 64'd0) : (len_q == 64'd0);
  assign stat_o.pos_next_zero = byte_present_i ? full : (pos_q == 3'd0);

  always_comb begin
    hash_d = hash_q;
    word_d = word_q;
    pos_d  = pos_q;
    len_d  = len_q;
    priority if (cmd_i.emit) begin
      hash_d = fnvws_pkg::FNV_BASIS;
      word_d = '0;
      pos_d  = '0;
      len_d  = '0;
    end else if (cmd_i.pad || cmd_i.len) begin
      hash_d = product;
    end else if (cmd_i.take && byte_present_i) begin
      len_d = len_inc;
      if (full) begin
        // word complete: absorb now
        hash_d = product;
        word_d = '0;
        pos_d  = '0;
      end else begin
        word_d = word_ins;
        pos_d  = pos_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= fnvws_pkg::FNV_BASIS;
      word_q <= '0;
      pos_q  <= '0;
      len_q  <= '0;
    end else begin
      hash_q <= hash_d;
      word_q <= word_d;
      pos_q  <= pos_d;
      len_q  <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= hash_q;
    end
  end

  assign hash_value_o = out_q;

endmodule

[sv/fnvws_ctrl.sv]
// Controller: sequences the final pad and length absorbs and owns the result valid.
`timescale 1ns / 1ps

module fnvws_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                last_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  fnvws_pkg::dp_stat_t stat_i,
  output fnvws_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (last_i) begin
            priority if (stat_i.len_next_zero) begin
              state_d = ST_EMIT;
            end else if (stat_i.pos_next_zero) begin
              state_d = ST_LEN;
            end else begin
              state_d = ST_PAD;
            end
          end
        end
      end
      ST_PAD: begin
        cmd_o.pad = 1'b1;
        state_d   = ST_LEN;
      end
      ST_LEN: begin
        cmd_o.len = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the result register is free
        if (slot_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
